@@ rtl/swrl_pkg.sv @@
// Shared types, constants and sizes of the sliding-window rate limiter.
package swrl_pkg;

  // Sizes
  localparam int USERS      = 64;
  localparam int LOG_DEPTH  = 16;
  localparam int TIME_BITS  = 32;

  localparam int USER_W     = (USERS > 1) ? $clog2(USERS) : 1;
  localparam int HEAD_W     = (LOG_DEPTH > 1) ? $clog2(LOG_DEPTH) : 1;
  localparam int CNT_W      = $clog2(LOG_DEPTH + 1);
  localparam int LOG_WORDS  = USERS * LOG_DEPTH;
  localparam int LOG_AW     = (LOG_WORDS > 1) ? $clog2(LOG_WORDS) : 1;

  // Field widths of items and registers
  localparam int OP_W       = 2;
  localparam int MAX_W      = 5;
  localparam int WIN_W      = 16;
  localparam int THR_W      = 9;
  localparam int PROD_W     = MAX_W + THR_W;
  localparam int REM_W      = 5;

  localparam logic [THR_W-1:0] THR_FULL = THR_W'(256);

  // Configuration register indexes
  localparam logic [1:0] REG_MAX_REQUESTS  = 2'd0;
  localparam logic [1:0] REG_WINDOW_LENGTH = 2'd1;
  localparam logic [1:0] REG_THROTTLE      = 2'd2;

  typedef enum logic [OP_W-1:0] {
    OP_REQUEST = 2'd0,
    OP_QUERY   = 2'd1,
    OP_CLEAR   = 2'd2,
    OP_NOP     = 2'd3
  } op_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_META_RD,
    ST_META_LD,
    ST_EXP_RD,
    ST_EXP_CHK,
    ST_DECIDE,
    ST_FINISH
  } state_t;

  // Per-user record kept in the meta RAM
  typedef struct packed {
    logic              known;
    logic [CNT_W-1:0]  count;
    logic [HEAD_W-1:0] head;
  } meta_t;

  localparam int META_W = $bits(meta_t);

  // Controller to datapath
  typedef struct packed {
    logic accept;
    logic meta_ld;
    logic meta_clear;
    logic res_zero;
    logic res_unknown;
    logic pop;
    logic keep_age;
    logic decide;
    logic out_load;
  } ctrl_cmd_t;

  // Datapath to controller
  typedef struct packed {
    op_e              op;
    logic             known;
    logic [CNT_W-1:0] count;
    logic             expired;
    logic             out_free;
  } dp_status_t;

endpackage

@@ rtl/swrl_ram.sv @@
// Generic single-port-write, registered-read RAM.
module swrl_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                           clk,
  input  logic                                           we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0]   waddr,
  input  logic [WIDTH-1:0]                               wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0]   raddr,
  output logic [WIDTH-1:0]                               rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ rtl/swrl_ctrl.sv @@
// Sequencer of the rate limiter: meta fetch, expiry walk, decision, result hand-off.
module swrl_ctrl (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  swrl_pkg::dp_status_t   status,
  output swrl_pkg::ctrl_cmd_t    cmd
);
  import swrl_pkg::*;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (in_valid) state_next = ST_META_RD;
      end
      ST_META_RD: state_next = ST_META_LD;
      ST_META_LD: begin
        priority if (status.op == OP_CLEAR || status.op == OP_NOP) begin
          state_next = ST_FINISH;
        end else if (status.op == OP_QUERY && !status.known) begin
          state_next = ST_FINISH;
        end else begin
          state_next = ST_EXP_RD;
        end
      end
      ST_EXP_RD: begin
        if (status.count == '0) state_next = ST_DECIDE;
        else state_next = ST_EXP_CHK;
      end
      ST_EXP_CHK: begin
        if (status.expired) state_next = ST_EXP_RD;
        else state_next = ST_DECIDE;
      end
      ST_DECIDE: state_next = ST_FINISH;
      ST_FINISH: begin
        if (status.out_free) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    unique case (state)
      ST_IDLE: begin
        // Take nothing while reset is held
        in_ready   = !rst;
        cmd.accept = in_valid && !rst;
      end
      ST_META_RD: ;
      ST_META_LD: begin
        cmd.meta_ld     = 1'b1;
        cmd.meta_clear  = (status.op == OP_CLEAR);
        cmd.res_zero    = (status.op == OP_CLEAR || status.op == OP_NOP);
        cmd.res_unknown = (status.op == OP_QUERY) && !status.known;
      end
      ST_EXP_RD: ;
      ST_EXP_CHK: begin
        cmd.pop      = status.expired;
        cmd.keep_age = !status.expired;
      end
      ST_DECIDE: cmd.decide = 1'b1;
      ST_FINISH: cmd.out_load = status.out_free;
      default: ;
    endcase
  end

endmodule

@@ rtl/swrl_dp.sv @@
// Datapath of the rate limiter: item registers, log and meta RAMs, limit and result logic.
module swrl_dp (
  input  logic                              clk,
  input  logic                              rst,
  input  swrl_pkg::ctrl_cmd_t               cmd,
  output swrl_pkg::dp_status_t              status,
  input  swrl_pkg::op_e                     in_op,
  input  logic [swrl_pkg::USER_W-1:0]       in_user,
  input  logic [swrl_pkg::TIME_BITS-1:0]    in_now,
  input  logic [swrl_pkg::MAX_W-1:0]        cfg_max,
  input  logic [swrl_pkg::WIN_W-1:0]        cfg_window,
  input  logic [swrl_pkg::THR_W-1:0]        cfg_throttle,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic                              out_allowed,
  output logic [swrl_pkg::REM_W-1:0]        out_remaining,
  output logic [swrl_pkg::WIN_W-1:0]        out_reset_time
);
  import swrl_pkg::*;

  // Item and working registers
  op_e                 op_q;
  logic [USER_W-1:0]   user_q;
  logic [TIME_BITS-1:0] now_q;
  logic [HEAD_W-1:0]   head_q;
  logic [CNT_W-1:0]    count_q;
  logic                known_q;
  logic [CNT_W-1:0]    lim_q;
  logic                oldest_q;
  logic [WIN_W-1:0]    age_q;

  logic                res_allowed;
  logic [REM_W-1:0]    res_rem;
  logic [WIN_W-1:0]    res_rt;

  logic [USERS-1:0]    valid_bits;

  // RAM ports
  logic                meta_we;
  meta_t               meta_wdata;
  logic [META_W-1:0]   meta_rdata;
  meta_t               meta_cur;
  logic                log_we;
  logic [LOG_AW-1:0]   log_waddr;
  logic [LOG_AW-1:0]   log_raddr;
  logic [TIME_BITS-1:0] log_rdata;

  // Combinational helpers
  logic [THR_W-1:0]    thr_sat;
  logic [PROD_W-1:0]   prod;
  logic [PROD_W-9:0]   lim_raw;
  logic [CNT_W-1:0]    limit;
  logic [TIME_BITS-1:0] age;
  logic                expired;
  logic                admit;
  logic [HEAD_W:0]     slot_sum;
  logic [HEAD_W-1:0]   slot;
  logic [CNT_W-1:0]    count_new;
  logic                known_new;
  logic [CNT_W-1:0]    rem_new;
  logic [WIN_W-1:0]    rt_new;
  logic [HEAD_W-1:0]   head_inc;

  function automatic logic [LOG_AW-1:0] log_addr(input logic [USER_W-1:0] u,
                                                 input logic [HEAD_W-1:0] s);
    log_addr = LOG_AW'(LOG_AW'(u) * LOG_AW'(LOG_DEPTH)) + LOG_AW'(s);
  endfunction

  swrl_ram #(.WIDTH(META_W), .DEPTH(USERS)) u_meta_ram (
    .clk   (clk),
    .we    (meta_we),
    .waddr (user_q),
    .wdata (meta_wdata),
    .raddr (user_q),
    .rdata (meta_rdata)
  );

  swrl_ram #(.WIDTH(TIME_BITS), .DEPTH(LOG_WORDS)) u_log_ram (
    .clk   (clk),
    .we    (log_we),
    .waddr (log_waddr),
    .wdata (now_q),
    .raddr (log_raddr),
    .rdata (log_rdata)
  );

  // A slot never written since reset reads as an empty, unknown user
  assign meta_cur = valid_bits[user_q] ? meta_t'(meta_rdata) : '0;

  // Effective limit: floor(max * throttle / 256), kept within 1..LOG_DEPTH
  always_comb begin
    thr_sat = (cfg_throttle > THR_FULL) ? THR_FULL : cfg_throttle;
    prod    = PROD_W'(cfg_max) * PROD_W'(thr_sat);
    lim_raw = prod[PROD_W-1:8];
    if (lim_raw == '0) begin
      limit = CNT_W'(1);
    end else if (lim_raw > (PROD_W-8)'(LOG_DEPTH)) begin
      limit = CNT_W'(LOG_DEPTH);
    end else begin
      limit = CNT_W'(lim_raw);
    end
  end

  // Age of the oldest entry, modulo the time width
  assign age     = now_q - log_rdata;
  assign expired = (age >= TIME_BITS'(cfg_window));
  assign log_raddr = log_addr(user_q, head_q);
  assign head_inc  = (head_q == HEAD_W'(LOG_DEPTH - 1)) ? '0 : head_q + HEAD_W'(1);

  // Decision and report
  always_comb begin
    admit     = (op_q == OP_REQUEST) && (count_q < lim_q);
    slot_sum  = (HEAD_W+1)'(head_q) + (HEAD_W+1)'(count_q);
    slot      = (slot_sum >= (HEAD_W+1)'(LOG_DEPTH)) ?
                HEAD_W'(slot_sum - (HEAD_W+1)'(LOG_DEPTH)) : HEAD_W'(slot_sum);
    count_new = admit ? count_q + CNT_W'(1) : count_q;
    known_new = known_q || (op_q == OP_REQUEST);
    rem_new   = (count_new < lim_q) ? lim_q - count_new : '0;
    if (oldest_q) begin
      rt_new = cfg_window - age_q;
    end else if (admit) begin
      rt_new = cfg_window;
    end else begin
      rt_new = '0;
    end
  end

  assign log_we    = cmd.decide && admit;
  assign log_waddr = log_addr(user_q, slot);
  assign meta_we   = cmd.decide || cmd.meta_clear;

  always_comb begin
    if (cmd.meta_clear) begin
      meta_wdata = '0;
    end else begin
      meta_wdata.known = known_new;
      meta_wdata.count = count_new;
      meta_wdata.head  = head_q;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid_bits <= '0;
    end else if (meta_we) begin
      valid_bits[user_q] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      op_q   <= in_op;
      user_q <= in_user;
      now_q  <= in_now;
    end
    if (cmd.meta_ld) begin
      head_q   <= meta_cur.head;
      count_q  <= meta_cur.count;
      known_q  <= meta_cur.known;
      lim_q    <= limit;
      oldest_q <= 1'b0;
    end
    if (cmd.pop) begin
      head_q  <= head_inc;
      count_q <= count_q - CNT_W'(1);
    end
    if (cmd.keep_age) begin
      oldest_q <= 1'b1;
      age_q    <= age[WIN_W-1:0];
    end
    priority if (cmd.res_zero) begin
      res_allowed <= 1'b0;
      res_rem     <= '0;
      res_rt      <= '0;
    end else if (cmd.res_unknown) begin
      res_allowed <= 1'b0;
      res_rem     <= REM_W'(cfg_max);
      res_rt      <= '0;
    end else if (cmd.decide) begin
      res_allowed <= admit;
      res_rem     <= REM_W'(rem_new);
      res_rt      <= rt_new;
    end
  end

  // Output register: holds a result while the next item is taken in
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_allowed    <= res_allowed;
      out_remaining  <= res_rem;
      out_reset_time <= res_rt;
    end
  end

  assign status.op       = op_q;
  assign status.known    = meta_cur.known;
  assign status.count    = count_q;
  assign status.expired  = expired;
  assign status.out_free = !out_valid || out_ready;

endmodule

@@ rtl/sliding_window_rate_limiter_unit.sv @@
// Top level of the per-user sliding-window-log rate limiter with its register port.
// Steps: clear, no-op or unknown-user query goes from meta fetch to hand-off; other items
//   walk expired entries out of their log (up to 16), then are decided and handed off.
// Flow: one item at a time, taken once the last result is in the output register.
// Reset: synchronous, active high; registers back to 10, 60, 256; all users forgotten.
module sliding_window_rate_limiter_unit (
  input  logic        clk,
  input  logic        rst,
  // Input items
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [39:0] s_tdata,   // [5:0] user_index, [37:6] now_time, [39:38] zero
  input  logic [1:0]  s_tuser,   // [1:0] operation
  // Result items
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [23:0] m_tdata,   // [0] allowed, [5:1] remaining, [21:6] reset_time, [23:22] zero
  // Register port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import swrl_pkg::*;

  logic [MAX_W-1:0] base_limit;
  logic [WIN_W-1:0] window_length;
  logic [THR_W-1:0] throttle;
  logic             cfg_wr;

  ctrl_cmd_t  cmd;
  dp_status_t status;

  logic             out_allowed;
  logic [REM_W-1:0] out_remaining;
  logic [WIN_W-1:0] out_reset_time;

  // Register port: zero wait states; writes land on the access phase
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      base_limit    <= MAX_W'(10);
      window_length <= WIN_W'(60);
      throttle      <= THR_W'(256);
    end else if (cfg_wr) begin
      unique case (paddr[3:2])
        REG_MAX_REQUESTS:  base_limit    <= pwdata[MAX_W-1:0];
        REG_WINDOW_LENGTH: window_length <= pwdata[WIN_W-1:0];
        REG_THROTTLE:      throttle      <= pwdata[THR_W-1:0];
        default: ;  // unmapped: drop the write
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      REG_MAX_REQUESTS:  prdata = 32'(base_limit);
      REG_WINDOW_LENGTH: prdata = 32'(window_length);
      REG_THROTTLE:      prdata = 32'(throttle);
      default:           prdata = '0;
    endcase
  end

  // Sequencer: one item walks fetch, expiry, decision and hand-off
  swrl_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_tvalid),
    .in_ready (s_tready),
    .status   (status),
    .cmd      (cmd)
  );

  // Datapath: log and per-user RAMs, limit arithmetic, result register
  swrl_dp u_dp (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .status         (status),
    .in_op          (op_e'(s_tuser)),
    .in_user        (s_tdata[USER_W-1:0]),
    .in_now         (s_tdata[USER_W+TIME_BITS-1:USER_W]),
    .cfg_max        (base_limit),
    .cfg_window     (window_length),
    .cfg_throttle   (throttle),
    .out_valid      (m_tvalid),
    .out_ready      (m_tready),
    .out_allowed    (out_allowed),
    .out_remaining  (out_remaining),
    .out_reset_time (out_reset_time)
  );

  // Pack the result item, first field lowest
  assign m_tdata = {2'b00, out_reset_time, out_remaining, out_allowed};

  // A result is never loaded over one still waiting to be taken
  assert property (@(posedge clk) disable iff (rst)
    cmd.out_load |-> (!m_tvalid || m_tready))
    else $error("result register overwritten while pending");

  // In the cycle after taking an item the block is not ready for another
  assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> !s_tready)
    else $error("second item taken while one is in progress");

  // The expiry walk pops only from a non-empty log
  assert property (@(posedge clk) disable iff (rst)
    cmd.pop |-> (status.count != '0))
    else $error("pop from an empty log");

  // A user's log never holds more entries than its ring
  assert property (@(posedge clk) disable iff (rst)
    cmd.decide |-> (status.count <= CNT_W'(LOG_DEPTH)))
    else $error("log count beyond ring depth");

endmodule
